// File: src/pcca_pkg.sv
// ----------------------------------------------------------------------------
// pcca_pkg
// shared types, opcodes and sizes for the pixel channel constant alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcca_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int CHAN_W       = 8;
  localparam int RAND_W       = MAX_CHANNELS * CHAN_W;
  localparam int DIV_STEPS    = CHAN_W;
  localparam int OP_W         = 4;
  localparam int EN_W         = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_AND = 4'd0,
    OP_OR  = 4'd1,
    OP_XOR = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_MUL = 4'd5,
    OP_DIV = 4'd6,
    OP_MOD = 4'd7,
    OP_RND = 4'd8
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATION = 2'd0,
    CFG_CONSTANT  = 2'd1,
    CFG_ENABLE    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] k;
    logic [EN_W-1:0]   en;
  } cfg_t;

  // rq: remainder in the upper byte, dividend shifting out / quotient shifting in below
  typedef struct packed {
    logic [MAX_CHANNELS-1:0][CHAN_W-1:0]   v;
    logic [MAX_CHANNELS-1:0][CHAN_W-1:0]   rnd;
    logic [MAX_CHANNELS-1:0][2*CHAN_W-1:0] rq;
  } chain_word_t;

endpackage

// File: src/pcca_if.sv
// ----------------------------------------------------------------------------
// pcca_in_if / pcca_out_if
// valid/ready channels for pixel words in and result words out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcca_in_if;
  import pcca_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] in_blue;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_alpha;
  logic [RAND_W-1:0] random_word;

  modport source (output valid, in_blue, in_green, in_red, in_alpha, random_word,
                  input ready);
  modport sink   (input valid, in_blue, in_green, in_red, in_alpha, random_word,
                  output ready);
endinterface

interface pcca_out_if;
  import pcca_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_alpha;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

// File: src/pcca_cell.sv
// ----------------------------------------------------------------------------
// pcca_cell
// one restoring divide step per channel lane, registered, with stall handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcca_cell #(
  parameter int CHANNELS = pcca_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pcca_pkg::CHAN_W-1:0] k,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  pcca_pkg::chain_word_t       up_word,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output pcca_pkg::chain_word_t       dn_word
);
  import pcca_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  chain_word_t word_r;
  chain_word_t word_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  always_comb begin
    word_nxt.v   = up_word.v;
    word_nxt.rnd = up_word.rnd;
  end

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_div
      logic [CHAN_W:0] trial;
      logic [CHAN_W:0] diff;
      logic            ge;
      always_comb begin
        trial = {up_word.rq[c][2*CHAN_W-1:CHAN_W], up_word.rq[c][CHAN_W-1]};
        ge    = trial >= {1'b0, k};
        diff  = ge ? (trial - {1'b0, k}) : trial;
        word_nxt.rq[c] = {diff[CHAN_W-1:0], up_word.rq[c][CHAN_W-2:0], ge};
      end
    end else begin : g_idle
      always_comb begin
        word_nxt.rq[c] = up_word.rq[c];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_valid && up_ready) begin
      valid_nxt = 1'b1;
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dn_ready |=> valid_r && $stable(word_r))
    else $error("cell dropped or changed a stalled word");
`endif

endmodule

// File: src/pcca_alu.sv
// ----------------------------------------------------------------------------
// pcca_alu
// per channel point operation at the end of the chain, into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcca_alu #(
  parameter int CHANNELS = pcca_pkg::CHANNELS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  pcca_pkg::cfg_t                                      cfg,
  input  logic                                                up_valid,
  output logic                                                up_ready,
  input  pcca_pkg::chain_word_t                               up_word,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [pcca_pkg::MAX_CHANNELS-1:0][pcca_pkg::CHAN_W-1:0] out_res
);
  import pcca_pkg::*;

  logic                                valid_r;
  logic                                valid_nxt;
  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] res_r;
  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] res_nxt;
  logic                                acc;

  assign up_ready  = !valid_r || out_ready;
  assign acc       = up_valid && up_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    logic [CHAN_W-1:0]   v;
    logic [CHAN_W-1:0]   rnd;
    logic [CHAN_W-1:0]   quo;
    logic [CHAN_W-1:0]   rem;
    logic [CHAN_W:0]     sum;
    logic [2*CHAN_W-1:0] prod;
    logic [CHAN_W-1:0]   op_res;
    logic                on;
    always_comb begin
      v    = up_word.v[c];
      rnd  = up_word.rnd[c];
      quo  = up_word.rq[c][CHAN_W-1:0];
      rem  = up_word.rq[c][2*CHAN_W-1:CHAN_W];
      sum  = {1'b0, v} + {1'b0, cfg.k};
      prod = {{CHAN_W{1'b0}}, v} * {{CHAN_W{1'b0}}, cfg.k};
      on   = cfg.en[c] && (c < CHANNELS);
      unique case (cfg.op)
        OP_AND:  op_res = v & cfg.k;
        OP_OR:   op_res = v | cfg.k;
        OP_XOR:  op_res = v ^ cfg.k;
        OP_ADD:  op_res = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
        OP_SUB:  op_res = (v > cfg.k) ? (v - cfg.k) : '0;
        OP_MUL:  op_res = (|prod[2*CHAN_W-1:CHAN_W]) ? '1 : prod[CHAN_W-1:0];
        OP_DIV:  op_res = (cfg.k == '0) ? v : quo;
        OP_MOD:  op_res = (cfg.k == '0) ? v : rem;
        OP_RND:  op_res = (v & ~cfg.k) | (rnd & cfg.k);
        default: op_res = v;
      endcase
      res_nxt[c] = on ? op_res : v;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (acc) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (cfg.op == OP_DIV || cfg.op == OP_MOD) && cfg.k == '0
      |=> res_r == $past(up_word.v))
    else $error("divide by zero did not pass the pixel");

  a_mask_off_pass: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cfg.en == '0 |=> res_r == $past(up_word.v))
    else $error("disabled channels were modified");

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_chk
    if (c < CHANNELS) begin : g_on
      a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc && cfg.op == OP_MOD && cfg.k != '0 && cfg.en[c]
          |=> res_r[c] < $past(cfg.k))
        else $error("modulo result not below the constant");
    end
  end
`endif

endmodule

// File: src/pixel_channel_constant_alu_top.sv
// ----------------------------------------------------------------------------
// pixel_channel_constant_alu_top
// pipeline: 8 divide cells + output reg, from input word to result word
// throughput: one word per cycle unless the output stalls; one step per cell
// stalls propagate back through the cells; bubbles are squeezed out
// reset: synchronous active-low rst_n empties the chain and restores the
// registers to and, constant 0, all channels enabled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_channel_constant_alu_top #(
  parameter int CHANNELS = pcca_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pcca_in_if.sink                         in_px,
  pcca_out_if.source                      out_px
);
  import pcca_pkg::*;

  logic [OP_W-1:0]   op_r;
  logic [CHAN_W-1:0] k_r;
  logic [EN_W-1:0]   en_r;
  cfg_t              cfg;

  logic [DIV_STEPS:0] st_valid;
  logic [DIV_STEPS:0] st_ready;
  chain_word_t        st_word [DIV_STEPS+1];

  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] res;
  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] pix;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_AND;
      k_r  <= '0;
      en_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPERATION: op_r <= cfg_wdata[OP_W-1:0];
        CFG_CONSTANT:  k_r  <= cfg_wdata[CHAN_W-1:0];
        CFG_ENABLE:    en_r <= cfg_wdata[EN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{op: op_r, k: k_r, en: en_r};

  // chain entry
  assign pix = {in_px.in_alpha, in_px.in_red, in_px.in_green, in_px.in_blue};

  always_comb begin
    st_word[0].v   = pix;
    st_word[0].rnd = in_px.random_word;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      st_word[0].rq[c] = {{CHAN_W{1'b0}}, pix[c]};
    end
  end

  assign st_valid[0] = in_px.valid;
  assign in_px.ready = st_ready[0];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    pcca_cell #(
      .CHANNELS(CHANNELS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .k       (k_r),
      .up_valid(st_valid[i]),
      .up_ready(st_ready[i]),
      .up_word (st_word[i]),
      .dn_valid(st_valid[i+1]),
      .dn_ready(st_ready[i+1]),
      .dn_word (st_word[i+1])
    );
  end

  pcca_alu #(
    .CHANNELS(CHANNELS)
  ) u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (st_valid[DIV_STEPS]),
    .up_ready (st_ready[DIV_STEPS]),
    .up_word  (st_word[DIV_STEPS]),
    .out_valid(out_px.valid),
    .out_ready(out_px.ready),
    .out_res  (res)
  );

  assign out_px.out_blue  = res[0];
  assign out_px.out_green = res[1];
  assign out_px.out_red   = res[2];
  assign out_px.out_alpha = res[3];

endmodule
